FILE: sv/rr96_pkg.sv
`default_nettype none

package rr96_pkg;

   // operand width in bits, a multiple of CELL_W, from 65 to 128
   localparam int OPERAND_WIDTH = 96;

   // fixed field widths of the request and the response
   localparam int LO_W = 64;
   localparam int HI_W = 32;

   // bits held by one cell of the chain
   localparam int CELL_W = 8;
   localparam int NUM_CELLS = OPERAND_WIDTH / CELL_W;

   // step counter
   localparam int CNT_W = $clog2(OPERAND_WIDTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // data passed from one cell to the next higher one
   typedef struct packed {
      logic rem_bit;
      logic dvd_bit;
      logic borrow;
   } link_type;

   // control broadcast to all cells
   typedef struct packed {
      logic load;
      logic step;
      logic ge;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: sv/rr96_req_if.sv
`default_nettype none

interface rr96_req_if
   import rr96_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [LO_W-1:0] dividend_lo;
   logic [HI_W-1:0] dividend_hi;
   logic [LO_W-1:0] divisor_lo;
   logic [HI_W-1:0] divisor_hi;

   modport source (
      output valid, dividend_lo, dividend_hi, divisor_lo, divisor_hi,
      input  ready
   );

   modport sink (
      input  valid, dividend_lo, dividend_hi, divisor_lo, divisor_hi,
      output ready
   );
endinterface

`default_nettype wire

FILE: sv/rr96_rsp_if.sv
`default_nettype none

interface rr96_rsp_if
   import rr96_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [LO_W-1:0] remainder_lo;
   logic [HI_W-1:0] remainder_hi;
   logic            div_by_zero;

   modport source (
      output valid, remainder_lo, remainder_hi, div_by_zero,
      input  ready
   );

   modport sink (
      input  valid, remainder_lo, remainder_hi, div_by_zero,
      output ready
   );
endinterface

`default_nettype wire

FILE: sv/rr96_cell.sv
`default_nettype none

module rr96_cell
   import rr96_pkg::*;
(
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic [CELL_W-1:0] load_dividend,
   input  wire logic [CELL_W-1:0] load_divisor,
   input  wire link_type          link_in,
   output link_type               link_out,
   output logic [CELL_W-1:0]      rem_out
);

   logic [CELL_W-1:0] rem_ff, rem_in;
   logic [CELL_W-1:0] dvd_ff, dvd_in;
   logic [CELL_W-1:0] dsr_ff, dsr_in;
   logic [CELL_W-1:0] shifted;
   logic [CELL_W:0]   diff;

   // slice of the shifted partial remainder and its trial difference
   always_comb begin
      shifted = {rem_ff[CELL_W-2:0], link_in.rem_bit};
      diff = {1'b0, shifted} - {1'b0, dsr_ff} - {{CELL_W{1'b0}}, link_in.borrow};
   end

   // outgoing link to the next higher cell
   always_comb begin
      link_out.rem_bit = rem_ff[CELL_W-1];
      link_out.dvd_bit = dvd_ff[CELL_W-1];
      link_out.borrow  = diff[CELL_W];
   end

   assign rem_out = rem_ff;

   // next slice state
   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      if (ctl.load) begin
         rem_in = '0;
         dvd_in = load_dividend;
         dsr_in = load_divisor;
      end else if (ctl.step) begin
         dvd_in = {dvd_ff[CELL_W-2:0], link_in.dvd_bit};
         rem_in = ctl.ge ? diff[CELL_W-1:0] : shifted;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

endmodule

`default_nettype wire

FILE: sv/restoring_remainder_96.sv
// operation: a request with a nonzero divisor runs 96 shift-subtract steps in the cell chain
// after acceptance, then one output load into the response register; a zero divisor skips the steps
// a new request is accepted only in idle, after the response of the last one has been loaded;
// that load waits while a held response has not been taken
// reset: synchronous, active high; clears the control state and the response valid
`default_nettype none

module restoring_remainder_96
   import rr96_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rr96_req_if.sink  req_chan,
   rr96_rsp_if.source rsp_chan
);

   localparam int WIDE_W = 2 * LO_W;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic dbz_ff, dbz_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [LO_W-1:0] rsp_lo_ff, rsp_lo_in;
   logic [HI_W-1:0] rsp_hi_ff, rsp_hi_in;
   logic rsp_dbz_ff, rsp_dbz_in;

   logic [WIDE_W-1:0] dividend_wide, divisor_wide, rem_wide;
   logic [OPERAND_WIDTH-1:0] dividend, divisor, rem;
   logic divisor_zero;
   logic out_free;
   logic out_load;
   logic last_step;
   cell_ctl_type ctl;
   link_type link [NUM_CELLS+1];

   // operands at the configured width
   always_comb begin
      dividend_wide = WIDE_W'({req_chan.dividend_hi, req_chan.dividend_lo});
      divisor_wide  = WIDE_W'({req_chan.divisor_hi, req_chan.divisor_lo});
      dividend      = dividend_wide[OPERAND_WIDTH-1:0];
      divisor       = divisor_wide[OPERAND_WIDTH-1:0];
      divisor_zero  = (divisor == '0);
   end

   // chain of remainder cells, low slice first
   assign link[0] = '{rem_bit: link[NUM_CELLS].dvd_bit, dvd_bit: 1'b0, borrow: 1'b0};

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      rr96_cell u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .load_dividend (dividend[k*CELL_W +: CELL_W]),
         .load_divisor  (divisor[k*CELL_W +: CELL_W]),
         .link_in       (link[k]),
         .link_out      (link[k+1]),
         .rem_out       (rem[k*CELL_W +: CELL_W])
      );
   end

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign last_step = (count_ff == CNT_W'(OPERAND_WIDTH - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = divisor_zero ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready = 1'b0;
      ctl.load       = 1'b0;
      ctl.step       = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            ctl.load       = req_chan.valid;
         end
         ST_RUN: begin
            ctl.step = 1'b1;
         end
         ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
      // subtract when the shifted remainder carries out or no borrow leaves the top
      ctl.ge = link[NUM_CELLS].rem_bit || !link[NUM_CELLS].borrow;
   end

   // step counter and divide-by-zero flag
   always_comb begin
      count_in = count_ff;
      dbz_in   = dbz_ff;
      if (ctl.load) begin
         count_in = '0;
         dbz_in   = divisor_zero;
      end else if (ctl.step) begin
         count_in = count_ff + 1'b1;
      end
   end

   // response register
   always_comb begin
      rem_wide     = WIDE_W'(rem);
      rsp_valid_in = rsp_valid_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_dbz_in   = rsp_dbz_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_lo_in    = dbz_ff ? '0 : rem_wide[LO_W-1:0];
         rsp_hi_in    = dbz_ff ? '0 : rem_wide[LO_W +: HI_W];
         rsp_dbz_in   = dbz_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dbz_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dbz_ff       <= dbz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_lo_ff  <= rsp_lo_in;
      rsp_hi_ff  <= rsp_hi_in;
      rsp_dbz_ff <= rsp_dbz_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.remainder_lo = rsp_lo_ff;
   assign rsp_chan.remainder_hi = rsp_hi_ff;
   assign rsp_chan.div_by_zero  = rsp_dbz_ff;

endmodule

`default_nettype wire
